/* design/fcf_pkg.sv */
`default_nettype none

package fcf_pkg;

  // field widths fixed by the item formats
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned DIM_W   = 11;
  localparam int unsigned BYTES_W = 22;
  localparam int unsigned CHG_W   = 2 * DIM_W;
  localparam int unsigned CNT_W   = 32;
  localparam int unsigned TOT_W   = 48;
  localparam int unsigned F21_W   = 21;

  localparam logic [F21_W-1:0] F21_MAX = '1;

  // default frame buffer geometry
  localparam int unsigned DEF_MAX_WIDTH  = 1024;
  localparam int unsigned DEF_MAX_HEIGHT = 1024;

  // one pixel request after frame control, entering the compare stage
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             do_cmp;
    logic             first;
    logic             last;
    logic             bump_lock;
    logic             bump_mal;
    logic             cmp_done;
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] frm_w;
    logic [DIM_W-1:0] frm_h;
  } fcf_pix_t;

  // running frame summary after the compare stage
  typedef struct packed {
    logic             last;
    logic             bump_lock;
    logic             bump_mal;
    logic             cmp_done;
    logic [CHG_W-1:0] chg;
    logic [DIM_W-1:0] min_c;
    logic [DIM_W-1:0] min_r;
    logic [DIM_W-1:0] max_c;
    logic [DIM_W-1:0] max_r;
    logic [DIM_W-1:0] frm_w;
    logic [DIM_W-1:0] frm_h;
  } fcf_sum_t;

endpackage

`default_nettype wire

/* design/fcf_if.sv */
`default_nettype none

// pixel request channel
interface fcf_pix_if import fcf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               cmd;
  logic [PIX_W-1:0]   pixel;
  logic [DIM_W-1:0]   frame_width;
  logic [DIM_W-1:0]   frame_height;
  logic [BYTES_W-1:0] buffer_bytes;
  logic               last_pixel;

  modport source (
    output valid, cmd, pixel, frame_width, frame_height, buffer_bytes, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, cmd, pixel, frame_width, frame_height, buffer_bytes, last_pixel,
    output ready
  );
endinterface

// frame statistics channel
interface fcf_stat_if import fcf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [F21_W-1:0] frame_changed_pixels;
  logic [CNT_W-1:0] lock_count;
  logic [CNT_W-1:0] compared_count;
  logic [CNT_W-1:0] unchanged_count;
  logic [CNT_W-1:0] partial_extent_count;
  logic [CNT_W-1:0] full_extent_count;
  logic [CNT_W-1:0] all_changed_count;
  logic [CNT_W-1:0] malformed_count;
  logic [TOT_W-1:0] total_changed_pixels;
  logic [F21_W-1:0] max_changed_pixels;
  logic [F21_W-1:0] max_box_pixels;

  modport source (
    output valid, frame_changed_pixels, lock_count, compared_count, unchanged_count,
           partial_extent_count, full_extent_count, all_changed_count, malformed_count,
           total_changed_pixels, max_changed_pixels, max_box_pixels,
    input  ready
  );
  modport sink (
    input  valid, frame_changed_pixels, lock_count, compared_count, unchanged_count,
           partial_extent_count, full_extent_count, all_changed_count, malformed_count,
           total_changed_pixels, max_changed_pixels, max_box_pixels,
    output ready
  );
endinterface

`default_nettype wire

/* design/fcf_ram.sv */
`default_nettype none

module fcf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* design/fcf_frame_ctl.sv */
`default_nettype none

module fcf_frame_ctl import fcf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT,
  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  fcf_pix_if.sink           pix_i,
  input  logic              s1_ld_i,
  output logic              s1_valid_o,
  output fcf_pix_t          s1_o,
  output logic              ram_we_o,
  output logic              ram_re_o,
  output logic [ADDR_W-1:0] ram_addr_o,
  output logic [PIX_W-1:0]  ram_wdata_o
);

  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int unsigned CR_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int unsigned POS_W = ((CR_W > DIM_W) ? CR_W : DIM_W) + 1;

  logic              mid_q, mid_d;
  logic              cmd_q, cmd_d;
  logic              bad_q, bad_d;
  logic              full_q, full_d;
  logic              over_q, over_d;
  logic              bv_q, bv_d;
  logic [DIM_W-1:0]  sw_q, sw_d;
  logic [DIM_W-1:0]  sh_q, sh_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [ADDR_W-1:0] rbase_q, rbase_d;
  logic              s1_v_q;
  fcf_pix_t          s1_q, s1_d;

  logic              accept;
  logic [CHG_W-1:0]  wh_in;
  logic              size_ok;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [ADDR_W-1:0] addr_cur;
  logic [DIM_W-1:0]  sw_cur;
  logic [DIM_W-1:0]  sh_cur;
  logic              we, re;

  assign pix_i.ready = s1_ld_i;
  assign accept      = pix_i.valid && s1_ld_i;

  // frame geometry check against the buffer and the store
  always_comb begin
    wh_in   = CHG_W'(pix_i.frame_width) * CHG_W'(pix_i.frame_height);
    size_ok = (pix_i.frame_width != '0) && (pix_i.frame_height != '0) &&
              (32'(pix_i.frame_width) <= MAX_WIDTH) &&
              (32'(pix_i.frame_height) <= MAX_HEIGHT) &&
              ({wh_in, 1'b0} <= {1'b0, pix_i.buffer_bytes});
  end

  // frame start, pixel position and frame end decisions
  always_comb begin
    mid_d   = mid_q;
    cmd_d   = cmd_q;
    bad_d   = bad_q;
    full_d  = full_q;
    over_d  = over_q;
    bv_d    = bv_q;
    sw_d    = sw_q;
    sh_d    = sh_q;
    col_d   = col_q;
    row_d   = row_q;
    addr_d  = addr_q;
    rbase_d = rbase_q;
    we      = 1'b0;
    re      = 1'b0;
    s1_d    = '0;

    // frame start
    if (!mid_q) begin
      s1_d.first = 1'b1;
      cmd_d   = pix_i.cmd;
      full_d  = 1'b0;
      over_d  = 1'b0;
      col_d   = '0;
      row_d   = '0;
      addr_d  = '0;
      rbase_d = '0;
      if (!pix_i.cmd) begin
        s1_d.bump_lock = 1'b1;
        bv_d = 1'b0;
        if (size_ok) begin
          sw_d  = pix_i.frame_width;
          sh_d  = pix_i.frame_height;
          bad_d = 1'b0;
        end else begin
          sw_d  = '0;
          sh_d  = '0;
          bad_d = 1'b1;
          s1_d.bump_mal = 1'b1;
        end
      end else if (!bv_q) begin
        bad_d = 1'b1;
      end else if (!size_ok || pix_i.frame_width != sw_q || pix_i.frame_height != sh_q) begin
        s1_d.bump_mal = 1'b1;
        bv_d  = 1'b0;
        sw_d  = '0;
        sh_d  = '0;
        bad_d = 1'b1;
      end else begin
        bad_d = 1'b0;
      end
    end

    col_cur  = col_d;
    row_cur  = row_d;
    addr_cur = addr_d;
    sw_cur   = sw_d;
    sh_cur   = sh_d;

    // pixel: store access and raster position step
    if (!bad_d) begin
      if (full_d) begin
        over_d = 1'b1;
      end else begin
        we = !cmd_d;
        re = cmd_d;
        s1_d.do_cmp = cmd_d;
        if (POS_W'(col_cur) + POS_W'(1) < POS_W'(sw_cur)) begin
          col_d  = col_cur + COL_W'(1);
          addr_d = addr_cur + ADDR_W'(1);
        end else begin
          col_d = '0;
          if (POS_W'(row_cur) + POS_W'(1) < POS_W'(sh_cur)) begin
            row_d   = row_cur + ROW_W'(1);
            rbase_d = rbase_d + ADDR_W'(MAX_WIDTH);
            addr_d  = rbase_d;
          end else begin
            full_d = 1'b1;
          end
        end
      end
    end

    // frame end
    if (pix_i.last_pixel) begin
      mid_d = 1'b0;
      if (!bad_d) begin
        if (!full_d || over_d) begin
          s1_d.bump_mal = 1'b1;
          bv_d = 1'b0;
          sw_d = '0;
          sh_d = '0;
        end else if (!cmd_d) begin
          bv_d = 1'b1;
        end else begin
          s1_d.cmp_done = 1'b1;
          bv_d = 1'b0;
          sw_d = '0;
          sh_d = '0;
        end
      end
    end else begin
      mid_d = 1'b1;
    end

    s1_d.pixel = pix_i.pixel;
    s1_d.last  = pix_i.last_pixel;
    s1_d.col   = DIM_W'(col_cur);
    s1_d.row   = DIM_W'(row_cur);
    s1_d.frm_w = sw_cur;
    s1_d.frm_h = sh_cur;
  end

  // frame control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q   <= 1'b0;
      cmd_q   <= 1'b0;
      bad_q   <= 1'b0;
      full_q  <= 1'b0;
      over_q  <= 1'b0;
      bv_q    <= 1'b0;
      sw_q    <= '0;
      sh_q    <= '0;
      col_q   <= '0;
      row_q   <= '0;
      addr_q  <= '0;
      rbase_q <= '0;
    end else if (accept) begin
      mid_q   <= mid_d;
      cmd_q   <= cmd_d;
      bad_q   <= bad_d;
      full_q  <= full_d;
      over_q  <= over_d;
      bv_q    <= bv_d;
      sw_q    <= sw_d;
      sh_q    <= sh_d;
      col_q   <= col_d;
      row_q   <= row_d;
      addr_q  <= addr_d;
      rbase_q <= rbase_d;
    end
  end

  // compare stage input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_ld_i) begin
      s1_v_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= s1_d;
    end
  end

  assign s1_valid_o  = s1_v_q;
  assign s1_o        = s1_q;
  assign ram_we_o    = accept && we;
  assign ram_re_o    = accept && re;
  assign ram_addr_o  = addr_cur;
  assign ram_wdata_o = pix_i.pixel;

  // a pixel either writes or reads the store, never both
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(ram_we_o && ram_re_o))
    else $error("store written and read by one pixel");

  // a held baseline always has a stored size
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    bv_q |-> (sw_q != '0 && sh_q != '0))
    else $error("baseline valid without a size");

endmodule

`default_nettype wire

/* design/fcf_diff.sv */
`default_nettype none

module fcf_diff import fcf_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s1_valid_i,
  input  fcf_pix_t         s1_i,
  input  logic [PIX_W-1:0] rdata_i,
  output logic             s1_ld_o,
  input  logic             take_i,
  output logic             s2_valid_o,
  output fcf_sum_t         s2_o
);

  logic [CHG_W-1:0] run_q;
  logic [DIM_W-1:0] minc_q, minr_q, maxc_q, maxr_q;
  logic             s2_v_q;
  fcf_sum_t         s2_q;

  logic             s2_ld;
  logic             move;
  logic             changed;
  logic [CHG_W-1:0] run0;
  logic [DIM_W-1:0] minc0, minr0, maxc0, maxr0;
  fcf_sum_t         sum_d;

  assign s2_ld   = !s2_v_q || take_i;
  assign s1_ld_o = !s1_valid_i || s2_ld;
  assign move    = s1_valid_i && s2_ld;

  // compare against the baseline and grow the changed box
  always_comb begin
    if (s1_i.first) begin
      run0  = '0;
      minc0 = s1_i.frm_w;
      minr0 = s1_i.frm_h;
      maxc0 = '0;
      maxr0 = '0;
    end else begin
      run0  = run_q;
      minc0 = minc_q;
      minr0 = minr_q;
      maxc0 = maxc_q;
      maxr0 = maxr_q;
    end
    changed         = s1_i.do_cmp && (rdata_i != s1_i.pixel);
    sum_d.last      = s1_i.last;
    sum_d.bump_lock = s1_i.bump_lock;
    sum_d.bump_mal  = s1_i.bump_mal;
    sum_d.cmp_done  = s1_i.cmp_done;
    sum_d.frm_w     = s1_i.frm_w;
    sum_d.frm_h     = s1_i.frm_h;
    sum_d.chg       = run0 + CHG_W'(changed);
    sum_d.min_c     = (changed && s1_i.col < minc0) ? s1_i.col : minc0;
    sum_d.min_r     = (changed && s1_i.row < minr0) ? s1_i.row : minr0;
    sum_d.max_c     = (changed && s1_i.col > maxc0) ? s1_i.col : maxc0;
    sum_d.max_r     = (changed && s1_i.row > maxr0) ? s1_i.row : maxr0;
  end

  // per-frame accumulators
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= '0;
      minc_q <= '0;
      minr_q <= '0;
      maxc_q <= '0;
      maxr_q <= '0;
    end else if (move) begin
      run_q  <= sum_d.chg;
      minc_q <= sum_d.min_c;
      minr_q <= sum_d.min_r;
      maxc_q <= sum_d.max_c;
      maxr_q <= sum_d.max_r;
    end
  end

  // summary register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_ld) begin
      s2_v_q <= s1_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      s2_q <= sum_d;
    end
  end

  assign s2_valid_o = s2_v_q;
  assign s2_o       = s2_q;

endmodule

`default_nettype wire

/* design/fcf_census.sv */
`default_nettype none

module fcf_census import fcf_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s2_valid_i,
  input  fcf_sum_t   s2_i,
  output logic       take_o,
  fcf_stat_if.source stat_o
);

  typedef struct packed {
    logic             last;
    logic             bump_lock;
    logic             bump_mal;
    logic             cmp_done;
    logic [CHG_W-1:0] chg;
    logic [DIM_W-1:0] bw;
    logic [DIM_W-1:0] bh;
    logic             full_ext;
    logic [CHG_W-1:0] wh;
  } dims_t;

  typedef struct packed {
    logic             last;
    logic             bump_lock;
    logic             bump_mal;
    logic             cmp_done;
    logic [CHG_W-1:0] chg;
    logic [CHG_W-1:0] area;
    logic             full_ext;
    logic             all_chg;
  } area_t;

  typedef struct packed {
    logic [F21_W-1:0] frame_changed;
    logic [CNT_W-1:0] lock;
    logic [CNT_W-1:0] compared;
    logic [CNT_W-1:0] unchanged;
    logic [CNT_W-1:0] partial;
    logic [CNT_W-1:0] full;
    logic [CNT_W-1:0] all_chg;
    logic [CNT_W-1:0] malformed;
    logic [TOT_W-1:0] total;
    logic [F21_W-1:0] max_chg;
    logic [F21_W-1:0] max_box;
  } stats_t;

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] v, logic en);
    logic [CNT_W-1:0] r;
    r = (en && v != '1) ? v + CNT_W'(1) : v;
    return r;
  endfunction

  function automatic logic [F21_W-1:0] clip21(logic [CHG_W-1:0] v);
    logic [F21_W-1:0] r;
    r = (v > CHG_W'(F21_MAX)) ? F21_MAX : F21_W'(v);
    return r;
  endfunction

  logic          s3_v_q, s4_v_q, out_v_q;
  dims_t         s3_q, s3_d;
  area_t         s4_q, s4_d;
  stats_t        st_q, st_d;
  stats_t        res_q;
  logic          ld3, ld4;
  logic          leave4;
  logic          load_res;
  logic [TOT_W:0] tot_sum;

  // stall only when a result meets a full output register
  assign ld4      = !s4_v_q || !s4_q.last || !out_v_q || stat_o.ready;
  assign ld3      = !s3_v_q || ld4;
  assign take_o   = ld3;
  assign leave4   = s4_v_q && ld4;
  assign load_res = leave4 && s4_q.last;

  // box extent and frame area
  always_comb begin
    s3_d.last      = s2_i.last;
    s3_d.bump_lock = s2_i.bump_lock;
    s3_d.bump_mal  = s2_i.bump_mal;
    s3_d.cmp_done  = s2_i.cmp_done;
    s3_d.chg       = s2_i.chg;
    s3_d.bw        = s2_i.max_c - s2_i.min_c + DIM_W'(1);
    s3_d.bh        = s2_i.max_r - s2_i.min_r + DIM_W'(1);
    s3_d.full_ext  = (s2_i.min_c == '0) && (s2_i.min_r == '0) &&
                     (s2_i.max_c + DIM_W'(1) == s2_i.frm_w) &&
                     (s2_i.max_r + DIM_W'(1) == s2_i.frm_h);
    s3_d.wh        = CHG_W'(s2_i.frm_w) * CHG_W'(s2_i.frm_h);
  end

  // box area and all-changed test
  always_comb begin
    s4_d.last      = s3_q.last;
    s4_d.bump_lock = s3_q.bump_lock;
    s4_d.bump_mal  = s3_q.bump_mal;
    s4_d.cmp_done  = s3_q.cmp_done;
    s4_d.chg       = s3_q.chg;
    s4_d.area      = CHG_W'(s3_q.bw) * CHG_W'(s3_q.bh);
    s4_d.full_ext  = s3_q.full_ext;
    s4_d.all_chg   = (s3_q.chg == s3_q.wh);
  end

  // statistics update
  always_comb begin
    st_d               = st_q;
    st_d.frame_changed = '0;
    tot_sum            = {1'b0, st_q.total} + (TOT_W + 1)'(s4_q.chg);
    st_d.lock          = sat_inc(st_q.lock, s4_q.bump_lock);
    st_d.malformed     = sat_inc(st_q.malformed, s4_q.bump_mal);
    if (s4_q.cmp_done) begin
      st_d.frame_changed = clip21(s4_q.chg);
      st_d.compared      = sat_inc(st_q.compared, 1'b1);
      st_d.total         = tot_sum[TOT_W] ? '1 : tot_sum[TOT_W-1:0];
      if (s4_q.chg > CHG_W'(st_q.max_chg)) begin
        st_d.max_chg = clip21(s4_q.chg);
      end
      if (s4_q.chg == '0) begin
        st_d.unchanged = sat_inc(st_q.unchanged, 1'b1);
      end else begin
        if (s4_q.area > CHG_W'(st_q.max_box)) begin
          st_d.max_box = clip21(s4_q.area);
        end
        st_d.full    = sat_inc(st_q.full, s4_q.full_ext);
        st_d.partial = sat_inc(st_q.partial, !s4_q.full_ext);
        st_d.all_chg = sat_inc(st_q.all_chg, s4_q.all_chg);
      end
    end
  end

  // stage valids, counters and output request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      st_q    <= '0;
    end else begin
      if (ld3) begin
        s3_v_q <= s2_valid_i;
      end
      if (ld4) begin
        s4_v_q <= s3_v_q;
      end
      if (leave4) begin
        st_q <= st_d;
      end
      if (load_res) begin
        out_v_q <= 1'b1;
      end else if (stat_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk_i) begin
    if (ld3 && s2_valid_i) begin
      s3_q <= s3_d;
    end
    if (ld4 && s3_v_q) begin
      s4_q <= s4_d;
    end
    if (load_res) begin
      res_q <= st_d;
    end
  end

  assign stat_o.valid                = out_v_q;
  assign stat_o.frame_changed_pixels = res_q.frame_changed;
  assign stat_o.lock_count           = res_q.lock;
  assign stat_o.compared_count       = res_q.compared;
  assign stat_o.unchanged_count      = res_q.unchanged;
  assign stat_o.partial_extent_count = res_q.partial;
  assign stat_o.full_extent_count    = res_q.full;
  assign stat_o.all_changed_count    = res_q.all_chg;
  assign stat_o.malformed_count      = res_q.malformed;
  assign stat_o.total_changed_pixels = res_q.total;
  assign stat_o.max_changed_pixels   = res_q.max_chg;
  assign stat_o.max_box_pixels       = res_q.max_box;

  // unchanged and partial frames are subsets of compared frames
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.unchanged <= st_q.compared) && (st_q.partial <= st_q.compared))
    else $error("frame class count above compared count");

  // lock count never goes back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> st_q.lock >= $past(st_q.lock))
    else $error("lock count decreased");

endmodule

`default_nettype wire

/* design/frame_change_footprint.sv */
// a frame's last pixel passes registers s1, s2, s3 and s4 before its result is valid
// throughput: one pixel per cycle unless stalled, one baseline memory access per pixel
// input stalls only while a result waits in the output register and another result
//   reaches the statistics stage
// reset clears frame control, the baseline-valid flag and all counters at once;
//   the baseline memory is not cleared and is only read after a complete capture
`default_nettype none

module frame_change_footprint import fcf_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcf_pix_if.sink    pix_i,
  fcf_stat_if.source stat_o
);

  localparam int unsigned DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic              s1_ld;
  logic              s1_valid;
  fcf_pix_t          s1;
  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_wdata;
  logic [PIX_W-1:0]  ram_rdata;
  logic              take;
  logic              s2_valid;
  fcf_sum_t          s2;

  // frame control and store addressing
  fcf_frame_ctl #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_ctl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pix_i       (pix_i),
    .s1_ld_i     (s1_ld),
    .s1_valid_o  (s1_valid),
    .s1_o        (s1),
    .ram_we_o    (ram_we),
    .ram_re_o    (ram_re),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata)
  );

  // baseline frame store
  fcf_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_base (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_addr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_addr),
    .rdata_o (ram_rdata)
  );

  // pixel compare and changed box
  fcf_diff u_diff (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s1_valid_i (s1_valid),
    .s1_i       (s1),
    .rdata_i    (ram_rdata),
    .s1_ld_o    (s1_ld),
    .take_i     (take),
    .s2_valid_o (s2_valid),
    .s2_o       (s2)
  );

  // frame statistics and result register
  fcf_census u_census (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s2_valid_i (s2_valid),
    .s2_i       (s2),
    .take_o     (take),
    .stat_o     (stat_o)
  );

endmodule

`default_nettype wire
